// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the core RTL. Define NO_ASSERTIONS
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property violated");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== rtl/core/msie_pkg.sv =====
// ----------------------------------------------------------------------------
// MIPS subset executor package
// Beat types, opcodes and ALU codes of the instruction executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msie_pkg;

   typedef struct packed {
      logic        op;
      logic [31:0] instr_word;
      logic [15:0] preload_addr;
      logic [7:0]  preload_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_write_enable;
      logic [4:0]  reg_write_index;
      logic [31:0] reg_write_value;
      logic        mem_write_enable;
      logic [15:0] mem_write_addr;
      logic [31:0] mem_write_value;
      logic        halt;
   } rsp_type;

   localparam logic OP_PRELOAD = 1'b0;
   localparam logic OP_EXEC    = 1'b1;

   localparam logic [5:0] OPC_RTYPE = 6'h00;
   localparam logic [5:0] OPC_ADDIU = 6'h09;
   localparam logic [5:0] OPC_LW    = 6'h23;
   localparam logic [5:0] OPC_SW    = 6'h2b;
   localparam logic [5:0] OPC_BEQ   = 6'h04;
   localparam logic [5:0] OPC_J     = 6'h02;

   localparam logic [2:0] ALU_ADDU = 3'd1;
   localparam logic [2:0] ALU_SUBU = 3'd3;
   localparam logic [2:0] ALU_AND  = 3'd4;
   localparam logic [2:0] ALU_OR   = 3'd5;
   localparam logic [2:0] ALU_NOR  = 3'd7;

   localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

   localparam int unsigned RSP_SLOTS = 4;

endpackage

`default_nettype wire

// ===== rtl/core/msie_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msie_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mips_subset_instruction_executor_top.sv =====
// ----------------------------------------------------------------------------
// MIPS subset instruction executor
// Runs addu, subu, and, or, nor, addiu, lw, sw, beq, j and the halt word
// against a register file, a byte-wide data memory and the program counter.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle while results drain; each result passes
// execute and write-back and waits in a four-entry output queue, so req_ready
// stays high while fewer than four beats are in flight. The register file is
// read on acceptance and written in write-back, with forwarding of the last
// two write-backs; the data memory (four byte lanes) is read and written in
// the execute cycle, so one write port per memory sets the one-beat-per-cycle
// figure. After reset the data memory is cleared one row of four bytes a
// cycle, with req_ready low. DMEM_BYTES must be a power of two (unchecked).
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mips_subset_instruction_executor_top
   import msie_pkg::*;
#(
   parameter int unsigned DMEM_BYTES = 65536
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int unsigned ADDR_BITS = $clog2(DMEM_BYTES);
   localparam int unsigned ROWS      = DMEM_BYTES / 4;
   localparam int unsigned ROW_BITS  = $clog2(ROWS);
   localparam int unsigned SLOT_BITS = $clog2(RSP_SLOTS);
   localparam int unsigned CNT_BITS  = $clog2(RSP_SLOTS + 1);

   // clear pass
   logic                clr_busy_ff, clr_busy_in;
   logic [ROW_BITS-1:0] clr_row_ff, clr_row_in;

   // execute stage
   logic        s1_valid_ff;
   req_type     s1_req_ff;
   logic [31:0] pc_ff, pc_in;
   logic        halted_ff, halted_in;

   // register file
   logic [31:0] rf_a_rdata, rf_b_rdata;
   logic [31:0] rf_valid_ff;
   logic        wbl_we_ff;
   logic [4:0]  wbl_idx_ff;
   logic [31:0] wbl_val_ff;

   // write-back stage
   logic        s2_valid_ff;
   rsp_type     s2_rsp_ff, s2_rsp_in;
   logic        s2_load_ff, s2_load_in;
   logic [1:0]  s2_off_ff;
   logic        s2_we;
   logic [31:0] s2_wval;
   logic [31:0] load_word;
   rsp_type     s2_out;

   // output queue
   rsp_type              fifo_ff [RSP_SLOTS];
   logic [SLOT_BITS-1:0] fifo_wptr_ff, fifo_rptr_ff;
   logic [CNT_BITS-1:0]  fifo_cnt_ff;
   logic [CNT_BITS-1:0]  inflight;
   logic                 fifo_push, fifo_pop;

   // execute decode
   logic [5:0]  s1_opc;
   logic [4:0]  s1_rs, s1_rt, s1_rd;
   logic [31:0] s1_a, s1_b, s1_imm, s1_pc4, s1_ea;
   logic        s1_exec, s1_run, s1_is_halt, s1_preload, s1_store;
   logic [ROW_BITS-1:0] s1_row;

   logic [7:0] lane_rdata [4];

   assign s1_opc = s1_req_ff.instr_word[31:26];
   assign s1_rs  = s1_req_ff.instr_word[25:21];
   assign s1_rt  = s1_req_ff.instr_word[20:16];
   assign s1_rd  = s1_req_ff.instr_word[15:11];

   // ---------------------------------------------------------------- intake
   assign inflight  = CNT_BITS'(s1_valid_ff) + CNT_BITS'(s2_valid_ff) + fifo_cnt_ff;
   assign req_ready = !clr_busy_ff && (inflight < CNT_BITS'(RSP_SLOTS));

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_row_in  = clr_row_ff;
      if (clr_busy_ff) begin
         clr_row_in = clr_row_ff + ROW_BITS'(1);
         if (clr_row_ff == ROW_BITS'(ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
         s1_valid_ff <= req_valid && req_ready;
      end
      s1_req_ff <= req_payload;
   end

   // ------------------------------------------------------- register file
   msie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock   (clock),
      .wr_en   (s2_we),
      .wr_addr (s2_rsp_ff.reg_write_index),
      .wr_data (s2_wval),
      .rd_addr (req_payload.instr_word[25:21]),
      .rd_data (rf_a_rdata)
   );

   msie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock   (clock),
      .wr_en   (s2_we),
      .wr_addr (s2_rsp_ff.reg_write_index),
      .wr_data (s2_wval),
      .rd_addr (req_payload.instr_word[20:16]),
      .rd_data (rf_b_rdata)
   );

   // forward: write-back in flight first, then the one just retired
   always_comb begin
      s1_a = rf_valid_ff[s1_rs] ? rf_a_rdata : '0;
      s1_b = rf_valid_ff[s1_rt] ? rf_b_rdata : '0;
      if (wbl_we_ff && wbl_idx_ff == s1_rs) begin
         s1_a = wbl_val_ff;
      end
      if (wbl_we_ff && wbl_idx_ff == s1_rt) begin
         s1_b = wbl_val_ff;
      end
      if (s2_we && s2_rsp_ff.reg_write_index == s1_rs) begin
         s1_a = s2_wval;
      end
      if (s2_we && s2_rsp_ff.reg_write_index == s1_rt) begin
         s1_b = s2_wval;
      end
   end

   // --------------------------------------------------------------- execute
   always_comb begin
      logic        wr;
      logic [4:0]  dst;
      logic [31:0] res;
      logic [31:0] next;
      logic        is_load;
      logic        we;

      s1_imm     = {{16{s1_req_ff.instr_word[15]}}, s1_req_ff.instr_word[15:0]};
      s1_pc4     = pc_ff + 32'd4;
      s1_ea      = s1_a + s1_imm;
      s1_exec    = s1_valid_ff && (s1_req_ff.op == OP_EXEC) && !halted_ff;
      s1_is_halt = s1_req_ff.instr_word == HALT_WORD;
      s1_run     = s1_exec && !s1_is_halt;
      s1_preload = s1_valid_ff && (s1_req_ff.op == OP_PRELOAD);

      wr       = 1'b0;
      dst      = '0;
      res      = '0;
      next     = pc_ff;
      is_load  = 1'b0;
      s1_store = 1'b0;

      if (s1_run) begin
         next = s1_pc4;
         unique case (s1_opc)
            OPC_RTYPE: begin
               dst = s1_rd;
               wr  = 1'b1;
               unique case (s1_req_ff.instr_word[2:0])
                  ALU_ADDU: res = s1_a + s1_b;
                  ALU_SUBU: res = s1_a - s1_b;
                  ALU_AND:  res = s1_a & s1_b;
                  ALU_OR:   res = s1_a | s1_b;
                  ALU_NOR:  res = ~(s1_a | s1_b);
                  default:  wr = 1'b0;
               endcase
            end
            OPC_ADDIU: begin
               wr  = 1'b1;
               dst = s1_rt;
               res = s1_ea;
            end
            OPC_LW: begin
               wr      = 1'b1;
               dst     = s1_rt;
               is_load = 1'b1;
            end
            OPC_SW: begin
               s1_store = 1'b1;
            end
            OPC_BEQ: begin
               if (s1_a == s1_b) begin
                  next = s1_pc4 + {s1_imm[29:0], 2'b00};
               end
            end
            OPC_J: begin
               next = {s1_pc4[31:28], s1_req_ff.instr_word[25:0], 2'b00};
            end
            default: ;
         endcase
      end

      we = wr && (dst != 5'd0);

      s2_rsp_in         = '0;
      s2_rsp_in.next_pc = next;
      s2_rsp_in.halt    = halted_ff || (s1_exec && s1_is_halt);
      if (we) begin
         s2_rsp_in.reg_write_enable = 1'b1;
         s2_rsp_in.reg_write_index  = dst;
         s2_rsp_in.reg_write_value  = res;
      end
      if (s1_store) begin
         s2_rsp_in.mem_write_enable = 1'b1;
         s2_rsp_in.mem_write_addr   = s1_ea[15:0];
         s2_rsp_in.mem_write_value  = s1_b;
      end
      s2_load_in = is_load && we;

      pc_in     = s1_run ? next : pc_ff;
      halted_in = halted_ff || (s1_exec && s1_is_halt);
   end

   assign s1_row = s1_ea[ADDR_BITS-1:2];

   // ----------------------------------------------------------- data memory
   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic                wr_en;
      logic [ROW_BITS-1:0] wr_row, rd_row;
      logic [7:0]          wr_byte;
      logic [1:0]          byte_pos;

      always_comb begin
         byte_pos = 2'(k) - s1_ea[1:0];
         rd_row   = s1_row + ((2'(k) < s1_ea[1:0]) ? ROW_BITS'(1) : ROW_BITS'(0));
         wr_en    = 1'b0;
         wr_row   = rd_row;
         wr_byte  = s1_b[{~byte_pos, 3'b000} +: 8];
         if (clr_busy_ff) begin
            wr_en   = 1'b1;
            wr_row  = clr_row_ff;
            wr_byte = '0;
         end else if (s1_preload) begin
            wr_en   = s1_req_ff.preload_addr[1:0] == 2'(k);
            wr_row  = s1_req_ff.preload_addr[ADDR_BITS-1:2];
            wr_byte = s1_req_ff.preload_byte;
         end else if (s1_store) begin
            wr_en = 1'b1;
         end
      end

      msie_ram #(.WIDTH(8), .DEPTH(ROWS)) u_dmem (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_row),
         .wr_data (wr_byte),
         .rd_addr (rd_row),
         .rd_data (lane_rdata[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff       <= '0;
         halted_ff   <= 1'b0;
         s2_valid_ff <= 1'b0;
         rf_valid_ff <= '0;
         wbl_we_ff   <= 1'b0;
      end else begin
         pc_ff       <= pc_in;
         halted_ff   <= halted_in;
         s2_valid_ff <= s1_valid_ff;
         wbl_we_ff   <= s2_we;
         if (s2_we) begin
            rf_valid_ff[s2_rsp_ff.reg_write_index] <= 1'b1;
         end
      end
      s2_rsp_ff  <= s2_rsp_in;
      s2_load_ff <= s2_load_in;
      s2_off_ff  <= s1_ea[1:0];
      wbl_idx_ff <= s2_rsp_ff.reg_write_index;
      wbl_val_ff <= s2_wval;
   end

   // ------------------------------------------------------------ write-back
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         load_word[31 - 8 * i -: 8] = lane_rdata[s2_off_ff + 2'(i)];
      end
   end

   assign s2_we   = s2_valid_ff && s2_rsp_ff.reg_write_enable;
   assign s2_wval = s2_load_ff ? load_word : s2_rsp_ff.reg_write_value;

   always_comb begin
      s2_out                 = s2_rsp_ff;
      s2_out.reg_write_value = s2_wval;
   end

   // ---------------------------------------------------------- output queue
   assign fifo_push   = s2_valid_ff;
   assign fifo_pop    = rsp_valid && rsp_ready;
   assign rsp_valid   = fifo_cnt_ff != '0;
   assign rsp_payload = fifo_ff[fifo_rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wptr_ff <= '0;
         fifo_rptr_ff <= '0;
         fifo_cnt_ff  <= '0;
      end else begin
         if (fifo_push) begin
            fifo_wptr_ff <= fifo_wptr_ff + SLOT_BITS'(1);
         end
         if (fifo_pop) begin
            fifo_rptr_ff <= fifo_rptr_ff + SLOT_BITS'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + CNT_BITS'(fifo_push) - CNT_BITS'(fifo_pop);
      end
      if (fifo_push) begin
         fifo_ff[fifo_wptr_ff] <= s2_out;
      end
   end

   // ------------------------------------------------------------ assertions
   `ASSERT_NEVER(a_credit_bound, clock, reset, inflight > CNT_BITS'(RSP_SLOTS))
   `ASSERT_NEVER(a_exec_during_clear, clock, reset, s1_valid_ff && clr_busy_ff)
   `ASSERT_NEVER(a_r0_never_written, clock, reset, rf_valid_ff[0])
   `ASSERT_PROP(a_halt_holds_pc, clock, reset, halted_ff |=> (halted_ff && $stable(pc_ff)))
   `ASSERT_PROP(a_rsp_index_nonzero, clock, reset, (rsp_valid && rsp_payload.reg_write_enable) |-> (rsp_payload.reg_write_index != 5'd0))

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS subset instruction executor testbench
// Drives preload and instruction beats through the request channel. A
// behavioral copy of the register file, data memory, PC and halt flag runs
// alongside the core and predicts each result beat, which is checked field
// by field. Directed cases come first, then random programs under three
// idling mixes, then the halt word.
// ----------------------------------------------------------------------------

module tb_top;
   import msie_pkg::*;

   localparam int unsigned DMEM_SIZE      = 65536;
   localparam int unsigned WATCHDOG_LIMIT = 50000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   logic [31:0] gpr_model [32];
   logic [7:0]  dmem_model [DMEM_SIZE];
   logic [31:0] pc_model     = '0;
   logic        halted_model = 1'b0;

   rsp_type     retire_q [$];
   int          errors      = 0;
   int unsigned send_idle   = 38;
   int unsigned rsp_idle    = 78;
   int unsigned stall_count = 0;

   mips_subset_instruction_executor_top #(
      .DMEM_BYTES(DMEM_SIZE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Instruction encoders
   // ------------------------------------------------------------------
   function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                          logic [4:0] shamt, logic [5:0] funct);
      return {OPC_RTYPE, rs, rt, rd, shamt, funct};
   endfunction

   function automatic logic [31:0] i_word(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
      return {opc, rs, rt, imm};
   endfunction

   function automatic logic [31:0] j_word(logic [25:0] target);
      return {OPC_J, target};
   endfunction

   // ------------------------------------------------------------------
   // Retire one beat against the model state and queue its result
   // ------------------------------------------------------------------
   task automatic retire_beat(input req_type item);
      rsp_type     r;
      logic [31:0] w, a, b, imm, pc4, next, res, ea;
      logic [5:0]  opc;
      logic [4:0]  rs, rt, rd, dst;
      logic        wr;
      int          i;
      r = '0;
      if (item.op == OP_PRELOAD) begin
         dmem_model[item.preload_addr % DMEM_SIZE] = item.preload_byte;
      end else if (!halted_model) begin
         w = item.instr_word;
         if (w == HALT_WORD) begin
            halted_model = 1'b1;
         end else begin
            opc  = w[31:26];
            rs   = w[25:21];
            rt   = w[20:16];
            rd   = w[15:11];
            a    = gpr_model[rs];
            b    = gpr_model[rt];
            imm  = {{16{w[15]}}, w[15:0]};
            pc4  = pc_model + 32'd4;
            next = pc4;
            wr   = 1'b0;
            dst  = '0;
            res  = '0;
            case (opc)
               OPC_RTYPE: begin
                  wr  = 1'b1;
                  dst = rd;
                  case (w[2:0])
                     ALU_ADDU: res = a + b;
                     ALU_SUBU: res = a - b;
                     ALU_AND:  res = a & b;
                     ALU_OR:   res = a | b;
                     ALU_NOR:  res = ~(a | b);
                     default:  wr = 1'b0;
                  endcase
               end
               OPC_ADDIU: begin
                  wr  = 1'b1;
                  dst = rt;
                  res = a + imm;
               end
               OPC_LW: begin
                  wr  = 1'b1;
                  dst = rt;
                  ea  = a + imm;
                  for (i = 0; i < 4; i++)
                     res = {res[23:0], dmem_model[(ea + i) % DMEM_SIZE]};
               end
               OPC_SW: begin
                  ea = a + imm;
                  for (i = 0; i < 4; i++)
                     dmem_model[(ea + i) % DMEM_SIZE] = b[31 - 8 * i -: 8];
                  r.mem_write_enable = 1'b1;
                  r.mem_write_addr   = ea[15:0];
                  r.mem_write_value  = b;
               end
               OPC_BEQ: begin
                  if (a == b)
                     next = pc4 + (imm << 2);
               end
               OPC_J: begin
                  next = {pc4[31:28], w[25:0], 2'b00};
               end
               default: ;
            endcase
            if (wr && dst != 5'd0) begin
               gpr_model[dst]     = res;
               r.reg_write_enable = 1'b1;
               r.reg_write_index  = dst;
               r.reg_write_value  = res;
            end
            pc_model = next;
         end
      end
      r.next_pc = pc_model;
      r.halt    = halted_model;
      retire_q.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   task automatic send_beat(input req_type item);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      retire_beat(item);
   endtask

   task automatic send_instr(input logic [31:0] w);
      req_type item;
      item.op           = OP_EXEC;
      item.instr_word   = w;
      item.preload_addr = 16'($urandom);
      item.preload_byte = 8'($urandom);
      send_beat(item);
   endtask

   task automatic send_preload(input logic [15:0] addr, input logic [7:0] data);
      req_type item;
      item.op           = OP_PRELOAD;
      item.instr_word   = $urandom;
      item.preload_addr = addr;
      item.preload_byte = data;
      send_beat(item);
   endtask

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (retire_q.size() == 0) begin
            $display("%0t ns: unexpected result beat, expected none actual %h",
                     $time, rsp_payload);
            errors++;
         end else begin
            want = retire_q.pop_front();
            check_field("next_pc", want.next_pc, rsp_payload.next_pc);
            check_field("reg_write_enable", 32'(want.reg_write_enable),
                        32'(rsp_payload.reg_write_enable));
            check_field("reg_write_index", 32'(want.reg_write_index),
                        32'(rsp_payload.reg_write_index));
            check_field("reg_write_value", want.reg_write_value, rsp_payload.reg_write_value);
            check_field("mem_write_enable", 32'(want.mem_write_enable),
                        32'(rsp_payload.mem_write_enable));
            check_field("mem_write_addr", 32'(want.mem_write_addr),
                        32'(rsp_payload.mem_write_addr));
            check_field("mem_write_value", want.mem_write_value, rsp_payload.mem_write_value);
            check_field("halt", 32'(want.halt), 32'(rsp_payload.halt));
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_preload_extremes();
      send_preload(16'hFFFF, 8'hFF);
      send_preload(16'h0000, 8'h00);
      send_preload(16'h0002, 8'h5A);
   endtask

   task automatic test_alu_ops();
      send_instr(i_word(OPC_ADDIU, 5'd0, 5'd1, 16'h7FFF));
      send_instr(i_word(OPC_ADDIU, 5'd0, 5'd2, 16'h8000));
      send_instr(i_word(OPC_ADDIU, 5'd2, 5'd3, 16'hFFFF));
      send_instr(r_word(5'd1, 5'd2, 5'd4, 5'd0, {3'b100, ALU_ADDU}));
      send_instr(r_word(5'd0, 5'd1, 5'd5, 5'd0, {3'b100, ALU_SUBU}));
      send_instr(r_word(5'd2, 5'd3, 5'd6, 5'd0, {3'b100, ALU_AND}));
      send_instr(r_word(5'd1, 5'd2, 5'd7, 5'd0, {3'b100, ALU_OR}));
      send_instr(r_word(5'd0, 5'd0, 5'd31, 5'd0, {3'b100, ALU_NOR}));
   endtask

   task automatic test_load_store_wrap();
      send_instr(i_word(OPC_SW, 5'd0, 5'd2, 16'hFFFE));
      send_instr(i_word(OPC_LW, 5'd0, 5'd9, 16'hFFFF));
      send_instr(i_word(OPC_SW, 5'd2, 5'd31, 16'h0000));
      send_instr(i_word(OPC_LW, 5'd1, 5'd10, 16'h7FFF));
   endtask

   task automatic test_branch_and_jump();
      send_instr(i_word(OPC_BEQ, 5'd0, 5'd0, 16'h7FFF));
      send_instr(i_word(OPC_BEQ, 5'd1, 5'd2, 16'h0000));
      send_instr(i_word(OPC_BEQ, 5'd3, 5'd3, 16'h8000));
      send_instr(j_word(26'h3FF_FFFF));
      send_instr(j_word(26'h000_0000));
   endtask

   task automatic test_r0_and_unknown_codes();
      send_instr(i_word(OPC_ADDIU, 5'd1, 5'd0, 16'h0005));
      send_instr(r_word(5'd1, 5'd2, 5'd9, 5'd0, 6'h20));
      send_instr(r_word(5'd1, 5'd2, 5'd9, 5'd0, 6'h22));
      send_instr(r_word(5'd1, 5'd2, 5'd9, 5'd0, 6'h26));
      send_instr(32'hFC00_0000);
   endtask

   function automatic logic [4:0] pick_reg();
      logic [4:0] r;
      if ($urandom_range(0, 3) == 0)
         r = 5'($urandom_range(0, 31));
      else
         r = 5'($urandom_range(0, 7));
      return r;
   endfunction

   function automatic logic [2:0] pick_alu();
      case ($urandom_range(0, 4))
         0:       return ALU_ADDU;
         1:       return ALU_SUBU;
         2:       return ALU_AND;
         3:       return ALU_OR;
         default: return ALU_NOR;
      endcase
   endfunction

   function automatic req_type random_beat();
      req_type     item;
      int unsigned kind;
      logic [15:0] imm;
      logic [4:0]  rs;
      logic [5:0]  opc;
      item.op           = OP_EXEC;
      item.instr_word   = $urandom;
      item.preload_addr = 16'($urandom);
      item.preload_byte = 8'($urandom);
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 2) == 0)
         imm = 16'($urandom);
      else
         imm = 16'($urandom_range(0, 63));
      rs = ($urandom_range(0, 1) == 0) ? 5'd0 : pick_reg();
      if (kind < 12) begin
         item.op = OP_PRELOAD;
         if ($urandom_range(0, 3) != 0)
            item.preload_addr = 16'($urandom_range(0, 68));
      end else if (kind < 40) begin
         item.instr_word = r_word(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
                                  {3'($urandom), pick_alu()});
      end else if (kind < 52) begin
         item.instr_word = i_word(OPC_ADDIU, pick_reg(), pick_reg(), imm);
      end else if (kind < 66) begin
         item.instr_word = i_word(OPC_LW, rs, pick_reg(), imm);
      end else if (kind < 80) begin
         item.instr_word = i_word(OPC_SW, rs, pick_reg(), imm);
      end else if (kind < 88) begin
         rs = pick_reg();
         item.instr_word = i_word(OPC_BEQ, rs, ($urandom_range(0, 1) == 0) ? rs : pick_reg(),
                                  imm);
      end else if (kind < 92) begin
         item.instr_word = j_word(26'($urandom));
      end else if (kind < 95) begin
         item.instr_word = r_word(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
                                  {3'($urandom), 3'(2 * $urandom_range(0, 1) + 4 *
                                   ($urandom_range(0, 1) & $urandom_range(0, 1)))});
         if (item.instr_word[2:0] == 3'd4)
            item.instr_word[2:0] = 3'd0;
      end else if (kind < 98) begin
         do opc = 6'($urandom_range(0, 63));
         while (opc == OPC_RTYPE || opc == OPC_ADDIU || opc == OPC_LW || opc == OPC_SW ||
                opc == OPC_BEQ || opc == OPC_J);
         item.instr_word[31:26] = opc;
      end
      if (item.instr_word == HALT_WORD)
         item.instr_word[0] = 1'b0;
      return item;
   endfunction

   task automatic test_random_program(input int count, input int unsigned send_pct,
                                      input int unsigned rsp_pct);
      send_idle = send_pct;
      rsp_idle  = rsp_pct;
      repeat (count) send_beat(random_beat());
   endtask

   task automatic test_halt();
      send_instr(HALT_WORD);
      send_instr(i_word(OPC_ADDIU, 5'd0, 5'd1, 16'h0001));
      send_preload(16'h1234, 8'hA5);
      send_instr(HALT_WORD);
   endtask

   initial begin
      for (int i = 0; i < 32; i++)
         gpr_model[i] = '0;
      for (int i = 0; i < DMEM_SIZE; i++)
         dmem_model[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_preload_extremes();
      test_alu_ops();
      test_load_store_wrap();
      test_branch_and_jump();
      test_r0_and_unknown_codes();
      test_random_program(210, 38, 78);
      test_random_program(210, 78, 38);
      test_random_program(210, 0, 0);
      test_halt();
      req_valid <= 1'b0;

      while (retire_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== mips_subset_instruction_executor_top.f =====
+incdir+rtl/core
rtl/core/msie_pkg.sv
rtl/core/msie_ram.sv
rtl/core/mips_subset_instruction_executor_top.sv
tb/tb_top.sv
